@@ rtl/uts_pkg.sv @@
// Package with the word types and constants of the UTF-8 sanitizer.
`timescale 1ns / 1ps

package uts_pkg;

    typedef struct packed {
        logic [7:0]  in_byte;
        logic [15:0] string_length;
        logic        end_of_string;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       run_last;
        logic       was_cut;
    } out_word_t;

    localparam int          MAX_RESULTS     = 8;
    localparam int          RES_IDX_W       = 3;
    localparam int          RES_CNT_W       = 4;
    localparam int          GROUPS          = 3;
    localparam logic [15:0] MAX_BYTES_RESET = 16'd4096;
    localparam logic [15:0] ELLIPSIS_LEN    = 16'd3;
    localparam logic [7:0]  CHAR_BAD        = 8'h3F;
    localparam logic [7:0]  CHAR_DOT        = 8'h2E;
    localparam logic [7:0]  LEAD2_LO        = 8'hC2;
    localparam logic [7:0]  LEAD2_HI        = 8'hDF;
    localparam logic [7:0]  LEAD3_LO        = 8'hE0;
    localparam logic [7:0]  LEAD3_HI        = 8'hEF;
    localparam logic [7:0]  LEAD4_LO        = 8'hF0;
    localparam logic [7:0]  LEAD4_HI        = 8'hF4;
    localparam logic [1:0]  CONT_TAG        = 2'b10;
    localparam logic [20:0] MIN_CP2         = 21'h80;
    localparam logic [20:0] MIN_CP3         = 21'h800;
    localparam logic [20:0] MIN_CP4         = 21'h10000;
    localparam logic [20:0] SURR_LO         = 21'hD800;
    localparam logic [20:0] SURR_HI         = 21'hDFFF;
    localparam logic [20:0] CP_MAX          = 21'h10FFFF;

endpackage

@@ rtl/utf8_sanitize_truncate.sv @@
// Streaming UTF-8 sanitizer with length-bounded output and ellipsis.
// The first result of a word is registered and offered in the cycle after the word is accepted.
// Throughput: one input word per cycle while each word gives at most one result and clean_ready is high.
// A word with k results holds the 8-entry result register until its last result is taken.
// Reset clears the string state except the pending bytes, empties the result register and sets max_bytes to 4096.
`timescale 1ns / 1ps

module utf8_sanitize_truncate #(
    parameter int COUNT_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 max_bytes_we,
    input  logic [15:0]          max_bytes_wdata,
    input  logic                 raw_valid,
    output logic                 raw_ready,
    input  uts_pkg::in_word_t    raw_word,
    output logic                 clean_valid,
    input  logic                 clean_ready,
    output uts_pkg::out_word_t   clean_word
);

    localparam int LIM_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [15:0]            max_bytes_reg;
    logic [7:0]             pend_reg [3];
    logic [7:0]             pend_next [3];
    logic [1:0]             pcount_reg, pcount_next;
    logic [2:0]             exp_reg, exp_next;
    logic [20:0]            cp_reg, cp_next;
    logic [COUNT_BITS-1:0]  emitted_reg, emitted_next;
    logic [COUNT_BITS-1:0]  limit_reg, limit_next;
    logic                   stopped_reg, stopped_next;
    logic                   inside_reg, inside_next;

    uts_pkg::out_word_t     slot_reg [uts_pkg::MAX_RESULTS];
    uts_pkg::out_word_t     slot_next [uts_pkg::MAX_RESULTS];
    logic [uts_pkg::RES_CNT_W-1:0] left_reg, left_next;
    logic [uts_pkg::RES_IDX_W-1:0] head_reg, head_next;

    logic raw_fire, clean_fire;
    logic [uts_pkg::RES_CNT_W-1:0] nres;

    assign clean_valid = (left_reg != '0);
    assign clean_word  = slot_reg[head_reg];
    assign clean_fire  = clean_valid && clean_ready;
    assign raw_ready   = (left_reg == '0) ||
                         ((left_reg == uts_pkg::RES_CNT_W'(1)) && clean_ready);
    assign raw_fire    = raw_valid && raw_ready;

    // Work for one byte: up to three emit groups, then the ellipsis and end marking.
    always_comb
    begin
        logic [7:0]            b;
        logic [15:0]           lim16;
        logic [LIM_W-1:0]      lim_wide;
        logic [LIM_W-1:0]      cnt_max_wide;
        logic [COUNT_BITS-1:0] limit_s, emitted_s, room, room_v;
        logic                  stop;
        logic [1:0]            pc_s;
        logic [2:0]            exp_s;
        logic [20:0]           cp_s, cp_acc;
        logic                  lead_now, bad_cp;
        logic [2:0]            g_cnt [uts_pkg::GROUPS];
        logic                  g_good [uts_pkg::GROUPS];
        logic [7:0]            g_bytes [4];
        b = raw_word.in_byte;
        lim16 = ((raw_word.string_length > max_bytes_reg) &&
                 (max_bytes_reg >= uts_pkg::ELLIPSIS_LEN)) ?
                (max_bytes_reg - uts_pkg::ELLIPSIS_LEN) : max_bytes_reg;
        lim_wide = LIM_W'(lim16);
        cnt_max_wide = LIM_W'({COUNT_BITS{1'b1}});
        if (inside_reg)
        begin
            limit_s   = limit_reg;
            emitted_s = emitted_reg;
            stop      = stopped_reg;
            pc_s      = pcount_reg;
            exp_s     = exp_reg;
            cp_s      = cp_reg;
        end
        else
        begin
            limit_s   = (lim_wide > cnt_max_wide) ? {COUNT_BITS{1'b1}}
                                                  : COUNT_BITS'(lim_wide);
            emitted_s = '0;
            stop      = 1'b0;
            pc_s      = '0;
            exp_s     = '0;
            cp_s      = '0;
        end
        room = limit_s - emitted_s;

        for (int i = 0; i < uts_pkg::GROUPS; i++)
        begin
            g_cnt[i]  = '0;
            g_good[i] = 1'b0;
        end
        for (int i = 0; i < 4; i++)
        begin
            g_bytes[i] = '0;
        end
        for (int i = 0; i < 3; i++)
        begin
            pend_next[i] = pend_reg[i];
        end
        pcount_next = pc_s;
        exp_next    = exp_s;
        cp_next     = cp_s;
        lead_now    = 1'b0;
        cp_acc      = {cp_s[14:0], b[5:0]};
        bad_cp      = 1'b0;

        if (exp_s == '0)
        begin
            lead_now = 1'b1;
        end
        else if (b[7:6] != uts_pkg::CONT_TAG)
        begin
            g_cnt[0]    = {1'b0, pc_s};
            pcount_next = '0;
            exp_next    = '0;
            lead_now    = 1'b1;
        end
        else if (({1'b0, pc_s} + 3'd1) < exp_s)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (pc_s == 2'(i))
                begin
                    pend_next[i] = b;
                end
            end
            pcount_next = pc_s + 2'd1;
            cp_next     = cp_acc;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                g_bytes[i] = pend_reg[i];
            end
            for (int i = 0; i < 4; i++)
            begin
                if (exp_s == 3'(i + 1))
                begin
                    g_bytes[i] = b;
                end
            end
            bad_cp = ((exp_s == 3'd2) && (cp_acc < uts_pkg::MIN_CP2)) ||
                     ((exp_s == 3'd3) && (cp_acc < uts_pkg::MIN_CP3)) ||
                     ((exp_s == 3'd4) && (cp_acc < uts_pkg::MIN_CP4)) ||
                     ((cp_acc >= uts_pkg::SURR_LO) && (cp_acc <= uts_pkg::SURR_HI)) ||
                     (cp_acc > uts_pkg::CP_MAX);
            g_cnt[1]    = exp_s;
            g_good[1]   = !bad_cp;
            pcount_next = '0;
            exp_next    = '0;
            cp_next     = '0;
        end

        if (lead_now)
        begin
            priority if (!b[7])
            begin
                g_cnt[1]   = 3'd1;
                g_good[1]  = 1'b1;
                g_bytes[0] = b;
            end
            else if ((b >= uts_pkg::LEAD2_LO) && (b <= uts_pkg::LEAD2_HI))
            begin
                exp_next     = 3'd2;
                cp_next      = {16'd0, b[4:0]};
                pend_next[0] = b;
                pcount_next  = 2'd1;
            end
            else if ((b >= uts_pkg::LEAD3_LO) && (b <= uts_pkg::LEAD3_HI))
            begin
                exp_next     = 3'd3;
                cp_next      = {17'd0, b[3:0]};
                pend_next[0] = b;
                pcount_next  = 2'd1;
            end
            else if ((b >= uts_pkg::LEAD4_LO) && (b <= uts_pkg::LEAD4_HI))
            begin
                exp_next     = 3'd4;
                cp_next      = {18'd0, b[2:0]};
                pend_next[0] = b;
                pcount_next  = 2'd1;
            end
            else
            begin
                g_cnt[1] = 3'd1;
            end
        end

        if (raw_word.end_of_string && (exp_next != '0))
        begin
            g_cnt[2] = {1'b0, pcount_next};
        end

        for (int i = 0; i < uts_pkg::MAX_RESULTS; i++)
        begin
            slot_next[i] = '0;
        end
        nres   = '0;
        room_v = room;
        for (int g = 0; g < uts_pkg::GROUPS; g++)
        begin
            if ((g_cnt[g] != '0) && !stop)
            begin
                if (g_good[g])
                begin
                    if (room_v >= COUNT_BITS'(g_cnt[g]))
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            if (3'(i) < g_cnt[g])
                            begin
                                slot_next[nres[uts_pkg::RES_IDX_W-1:0]] =
                                    '{out_byte: g_bytes[i], byte_present: 1'b1,
                                      run_last: 1'b0, was_cut: 1'b0};
                                nres = nres + 1'b1;
                            end
                        end
                        room_v = room_v - COUNT_BITS'(g_cnt[g]);
                    end
                    else
                    begin
                        stop = 1'b1;
                    end
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        if (3'(i) < g_cnt[g])
                        begin
                            if (room_v != '0)
                            begin
                                slot_next[nres[uts_pkg::RES_IDX_W-1:0]] =
                                    '{out_byte: uts_pkg::CHAR_BAD, byte_present: 1'b1,
                                      run_last: 1'b0, was_cut: 1'b0};
                                nres   = nres + 1'b1;
                                room_v = room_v - 1'b1;
                            end
                            else
                            begin
                                stop = 1'b1;
                            end
                        end
                    end
                end
            end
        end

        if (raw_word.end_of_string)
        begin
            if (stop && (max_bytes_reg >= uts_pkg::ELLIPSIS_LEN))
            begin
                for (int i = 0; i < 3; i++)
                begin
                    slot_next[nres[uts_pkg::RES_IDX_W-1:0]] =
                        '{out_byte: uts_pkg::CHAR_DOT, byte_present: 1'b1,
                          run_last: 1'b0, was_cut: 1'b1};
                    nres = nres + 1'b1;
                end
            end
            if (nres == '0)
            begin
                slot_next[0] = '{out_byte: 8'd0, byte_present: 1'b0,
                                 run_last: 1'b1, was_cut: stop};
                nres = uts_pkg::RES_CNT_W'(1);
            end
            else
            begin
                slot_next[3'(nres - 1'b1)].run_last = 1'b1;
            end
            pcount_next  = '0;
            exp_next     = '0;
            cp_next      = '0;
            emitted_next = '0;
            limit_next   = '0;
            stopped_next = 1'b0;
            inside_next  = 1'b0;
        end
        else
        begin
            emitted_next = limit_s - room_v;
            limit_next   = limit_s;
            stopped_next = stop;
            inside_next  = 1'b1;
        end
    end

    always_comb
    begin
        left_next = left_reg;
        head_next = head_reg;
        if (raw_fire)
        begin
            left_next = nres;
            head_next = '0;
        end
        else if (clean_fire)
        begin
            left_next = left_reg - 1'b1;
            head_next = head_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= uts_pkg::MAX_BYTES_RESET;
            pcount_reg    <= '0;
            exp_reg       <= '0;
            cp_reg        <= '0;
            emitted_reg   <= '0;
            limit_reg     <= '0;
            stopped_reg   <= 1'b0;
            inside_reg    <= 1'b0;
            left_reg      <= '0;
            head_reg      <= '0;
        end
        else
        begin
            if (max_bytes_we)
            begin
                max_bytes_reg <= max_bytes_wdata;
            end
            if (raw_fire)
            begin
                pcount_reg  <= pcount_next;
                exp_reg     <= exp_next;
                cp_reg      <= cp_next;
                emitted_reg <= emitted_next;
                limit_reg   <= limit_next;
                stopped_reg <= stopped_next;
                inside_reg  <= inside_next;
            end
            left_reg <= left_next;
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (raw_fire)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pend_reg[i] <= pend_next[i];
            end
            for (int i = 0; i < uts_pkg::MAX_RESULTS; i++)
            begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

endmodule

@@ sim/sanitize_check.sv @@
// Checker that predicts the sanitized output words of the UTF-8 sanitizer and compares them.
`timescale 1ns / 1ps

module sanitize_check (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                max_bytes_we,
    input  logic [15:0]         max_bytes_wdata,
    input  logic                raw_valid,
    input  logic                raw_ready,
    input  uts_pkg::in_word_t   raw_word,
    input  logic                clean_valid,
    input  logic                clean_ready,
    input  uts_pkg::out_word_t  clean_word,
    output int                  mismatches,
    output int                  due_count
);

    localparam int unsigned COUNT_MAX = 65535;

    logic [15:0]        max_bytes_q;
    logic [7:0]         held [3];
    logic [7:0]         char_bytes [4];
    int unsigned        held_count;
    int unsigned        seq_len;
    int unsigned        emitted;
    int unsigned        content_cap;
    logic [20:0]        cp_acc;
    logic               cut_off;
    logic               in_string;
    uts_pkg::out_word_t burst [uts_pkg::MAX_RESULTS];
    int                 burst_n;
    uts_pkg::out_word_t clean_due [$];
    int                 err_total = 0;

    function automatic void put_word(logic [7:0] b, logic present);
        uts_pkg::out_word_t w;
        if (burst_n < uts_pkg::MAX_RESULTS)
        begin
            w.out_byte = b;
            w.byte_present = present;
            w.run_last = 1'b0;
            w.was_cut = cut_off;
            burst[burst_n] = w;
            burst_n++;
        end
    endfunction

    function automatic void put_bad(int unsigned n);
        for (int unsigned i = 0; i < n; i++)
        begin
            if (cut_off)
                return;
            if (emitted + 1 > content_cap)
            begin
                cut_off = 1'b1;
                return;
            end
            emitted++;
            put_word(uts_pkg::CHAR_BAD, 1'b1);
        end
    endfunction

    function automatic void put_char(int unsigned n);
        if (cut_off)
            return;
        if (emitted + n > content_cap)
        begin
            cut_off = 1'b1;
            return;
        end
        emitted += n;
        for (int unsigned i = 0; i < n; i++)
            put_word(char_bytes[i], 1'b1);
    endfunction

    function automatic void take_lead(logic [7:0] b);
        if (b <= 8'h7F)
        begin
            char_bytes[0] = b;
            put_char(1);
            return;
        end
        if (b >= uts_pkg::LEAD2_LO && b <= uts_pkg::LEAD2_HI)
        begin
            seq_len = 2;
            cp_acc = {16'b0, b[4:0]};
        end
        else if (b >= uts_pkg::LEAD3_LO && b <= uts_pkg::LEAD3_HI)
        begin
            seq_len = 3;
            cp_acc = {17'b0, b[3:0]};
        end
        else if (b >= uts_pkg::LEAD4_LO && b <= uts_pkg::LEAD4_HI)
        begin
            seq_len = 4;
            cp_acc = {18'b0, b[2:0]};
        end
        else
        begin
            put_bad(1);
            return;
        end
        held[0] = b;
        held_count = 1;
    endfunction

    function automatic void take_byte(logic [7:0] b);
        int unsigned n;
        logic        bad;
        if (seq_len == 0)
        begin
            take_lead(b);
            return;
        end
        if (b[7:6] != uts_pkg::CONT_TAG)
        begin
            put_bad(held_count);
            held_count = 0;
            seq_len = 0;
            take_lead(b);
            return;
        end
        cp_acc = {cp_acc[14:0], b[5:0]};
        if (held_count + 1 < seq_len && held_count < 3)
        begin
            held[held_count] = b;
            held_count++;
            return;
        end
        n = seq_len;
        for (int i = 0; i < 3; i++)
            char_bytes[i] = held[i];
        char_bytes[n - 1] = b;
        bad = (n == 2 && cp_acc < uts_pkg::MIN_CP2) ||
              (n == 3 && cp_acc < uts_pkg::MIN_CP3) ||
              (n == 4 && cp_acc < uts_pkg::MIN_CP4) ||
              (cp_acc >= uts_pkg::SURR_LO && cp_acc <= uts_pkg::SURR_HI) ||
              cp_acc > uts_pkg::CP_MAX;
        if (bad)
            put_bad(n);
        else
            put_char(n);
        held_count = 0;
        seq_len = 0;
        cp_acc = '0;
    endfunction

    function automatic void clear_string();
        for (int i = 0; i < 3; i++)
            held[i] = 8'h00;
        held_count = 0;
        seq_len = 0;
        cp_acc = '0;
        emitted = 0;
        content_cap = 0;
        cut_off = 1'b0;
        in_string = 1'b0;
    endfunction

    function automatic void sanitize_word(uts_pkg::in_word_t w);
        int unsigned lim;
        burst_n = 0;
        if (!in_string)
        begin
            in_string = 1'b1;
            lim = (w.string_length > max_bytes_q && max_bytes_q >= 3) ?
                  max_bytes_q - 3 : max_bytes_q;
            content_cap = (lim > COUNT_MAX) ? COUNT_MAX : lim;
            emitted = 0;
            cut_off = 1'b0;
            held_count = 0;
            seq_len = 0;
            cp_acc = '0;
        end
        take_byte(w.in_byte);
        if (w.end_of_string)
        begin
            if (seq_len != 0)
                put_bad(held_count);
            if (cut_off && max_bytes_q >= 3)
                for (int i = 0; i < 3; i++)
                    put_word(uts_pkg::CHAR_DOT, 1'b1);
            if (burst_n == 0)
                put_word(8'h00, 1'b0);
            burst[burst_n - 1].run_last = 1'b1;
            clear_string();
        end
        for (int i = 0; i < burst_n; i++)
            clean_due.insert(clean_due.size(), burst[i]);
    endfunction

    function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            err_total++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        uts_pkg::out_word_t want;
        if (!rst_n)
        begin
            max_bytes_q = uts_pkg::MAX_BYTES_RESET;
            clear_string();
            clean_due.delete();
            due_count <= 0;
            mismatches <= err_total;
        end
        else
        begin
            if (clean_valid && clean_ready)
            begin
                if (clean_due.size() == 0)
                begin
                    $error("unexpected word: out_byte %h, byte_present %b, run_last %b, %s %b",
                           clean_word.out_byte, clean_word.byte_present,
                           clean_word.run_last, "was_cut", clean_word.was_cut);
                    err_total++;
                end
                else
                begin
                    want = clean_due[0];
                    clean_due.delete(0);
                    compare_field("out_byte", want.out_byte, clean_word.out_byte);
                    compare_field("byte_present", 8'(want.byte_present),
                                  8'(clean_word.byte_present));
                    compare_field("run_last", 8'(want.run_last), 8'(clean_word.run_last));
                    compare_field("was_cut", 8'(want.was_cut), 8'(clean_word.was_cut));
                end
            end
            if (max_bytes_we)
                max_bytes_q = max_bytes_wdata;
            if (raw_valid && raw_ready)
                sanitize_word(raw_word);
            due_count <= clean_due.size();
            mismatches <= err_total;
        end
    end

endmodule

@@ sim/tb.sv @@
// Top of the UTF-8 sanitizer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               max_bytes_we = 1'b0;
    logic [15:0]        max_bytes_wdata = 16'h0000;
    logic               raw_valid = 1'b0;
    logic               raw_ready;
    uts_pkg::in_word_t  raw_word = '0;
    logic               clean_valid;
    logic               clean_ready = 1'b0;
    uts_pkg::out_word_t clean_word;
    int                 mismatches;
    int                 due_count;
    bit                 steady = 1'b0;
    int                 bytes_sent = 0;
    int                 strings_sent = 0;
    int                 settings_used = 0;
    int                 words_taken = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    utf8_sanitize_truncate uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .max_bytes_we    (max_bytes_we),
        .max_bytes_wdata (max_bytes_wdata),
        .raw_valid       (raw_valid),
        .raw_ready       (raw_ready),
        .raw_word        (raw_word),
        .clean_valid     (clean_valid),
        .clean_ready     (clean_ready),
        .clean_word      (clean_word)
    );

    sanitize_check sanitize_check_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .max_bytes_we    (max_bytes_we),
        .max_bytes_wdata (max_bytes_wdata),
        .raw_valid       (raw_valid),
        .raw_ready       (raw_ready),
        .raw_word        (raw_word),
        .clean_valid     (clean_valid),
        .clean_ready     (clean_ready),
        .clean_word      (clean_word),
        .mismatches      (mismatches),
        .due_count       (due_count)
    );

    function automatic logic [7:0] cont_byte();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    function automatic logic [15:0] pick_length(int n);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return 16'(n);
        if (r < 8)
            return 16'($urandom_range(1, 40));
        return 16'($urandom_range(1, 65535));
    endfunction

    function automatic void append_byte(ref logic [7:0] s[$], input logic [7:0] b);
        s.insert(s.size(), b);
    endfunction

    task automatic add_char(ref logic [7:0] s[$]);
        int         kind;
        int         len;
        logic [7:0] lead;
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            append_byte(s, 8'($urandom_range(0, 127)));
        end
        else if (kind < 45)
        begin
            append_byte(s, 8'($urandom_range(8'hC2, 8'hDF)));
            append_byte(s, cont_byte());
        end
        else if (kind < 60)
        begin
            lead = 8'($urandom_range(8'hE0, 8'hEF));
            append_byte(s, lead);
            if (lead == 8'hE0)
                append_byte(s, 8'($urandom_range(8'hA0, 8'hBF)));
            else if (lead == 8'hED)
                append_byte(s, 8'($urandom_range(8'h80, 8'h9F)));
            else
                append_byte(s, cont_byte());
            append_byte(s, cont_byte());
        end
        else if (kind < 72)
        begin
            lead = 8'($urandom_range(8'hF0, 8'hF4));
            append_byte(s, lead);
            if (lead == 8'hF0)
                append_byte(s, 8'($urandom_range(8'h90, 8'hBF)));
            else if (lead == 8'hF4)
                append_byte(s, 8'($urandom_range(8'h80, 8'h8F)));
            else
                append_byte(s, cont_byte());
            append_byte(s, cont_byte());
            append_byte(s, cont_byte());
        end
        else if (kind < 78)
        begin
            case ($urandom_range(0, 2))
                0:       append_byte(s, 8'($urandom_range(8'h80, 8'hBF)));
                1:       append_byte(s, 8'($urandom_range(8'hC0, 8'hC1)));
                default: append_byte(s, 8'($urandom_range(8'hF5, 8'hFF)));
            endcase
        end
        else if (kind < 84)
        begin
            len = $urandom_range(2, 4);
            case (len)
                2:       append_byte(s, 8'($urandom_range(8'hC2, 8'hDF)));
                3:       append_byte(s, 8'($urandom_range(8'hE1, 8'hEC)));
                default: append_byte(s, 8'($urandom_range(8'hF1, 8'hF3)));
            endcase
            repeat ($urandom_range(0, len - 2))
                append_byte(s, cont_byte());
        end
        else if (kind < 90)
        begin
            if ($urandom_range(0, 1))
            begin
                append_byte(s, 8'hE0);
                append_byte(s, 8'($urandom_range(8'h80, 8'h9F)));
                append_byte(s, cont_byte());
            end
            else
            begin
                append_byte(s, 8'hF0);
                append_byte(s, 8'($urandom_range(8'h80, 8'h8F)));
                append_byte(s, cont_byte());
                append_byte(s, cont_byte());
            end
        end
        else if (kind < 94)
        begin
            append_byte(s, 8'hED);
            append_byte(s, 8'($urandom_range(8'hA0, 8'hBF)));
            append_byte(s, cont_byte());
        end
        else if (kind < 97)
        begin
            append_byte(s, 8'hF4);
            append_byte(s, 8'($urandom_range(8'h90, 8'hBF)));
            append_byte(s, cont_byte());
            append_byte(s, cont_byte());
        end
        else
        begin
            append_byte(s, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic build_string(ref logic [7:0] s[$]);
        int n;
        s.delete();
        n = $urandom_range(1, 12);
        repeat (n)
            add_char(s);
    endtask

    task automatic push_byte(logic [7:0] b, logic [15:0] len, logic eos);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            raw_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        raw_valid <= 1'b1;
        raw_word <= '{in_byte: b, string_length: len, end_of_string: eos};
        @(posedge clk);
        while (!raw_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_string(ref logic [7:0] s[$], input logic [15:0] len);
        steady = ($urandom_range(0, 4) == 0);
        foreach (s[i])
            push_byte(s[i], len, i == s.size() - 1);
        strings_sent++;
    endtask

    task automatic settle();
        raw_valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_max_bytes(logic [15:0] v);
        settle();
        max_bytes_we <= 1'b1;
        max_bytes_wdata <= v;
        @(posedge clk);
        max_bytes_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin : drain
        int gap;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                clean_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            clean_ready <= 1'b1;
            @(posedge clk);
            while (!clean_valid)
                @(posedge clk);
            words_taken++;
        end
    end

    initial
    begin : stimulus
        logic [7:0]  s[$];
        logic [15:0] val;
        int          stop_at;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        s = '{8'h00, 8'hC2, 8'h80, 8'hFF, 8'hE0, 8'h9F, 8'hBF, 8'hED, 8'hA0,
              8'h80, 8'hC2, 8'h41, 8'hF4, 8'h90, 8'h80, 8'h80, 8'hE2, 8'h82};
        send_string(s, 16'(s.size()));

        set_max_bytes(16'd6);
        s = '{8'h41, 8'hC3, 8'hA9, 8'h42, 8'hE2, 8'h82};
        foreach (s[i])
            push_byte(s[i], 16'd9, 1'b0);
        set_max_bytes(16'd2);
        push_byte(8'hAC, 16'd9, 1'b1);
        strings_sent++;

        set_max_bytes(16'd4);
        s = '{8'h41, 8'h42, 8'h43, 8'h44, 8'h45};
        send_string(s, 16'd1);

        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0:       val = 16'd0;
                1:       val = 16'd1;
                2:       val = 16'd2;
                3:       val = 16'd3;
                4:       val = 16'hFFFF;
                5:       val = uts_pkg::MAX_BYTES_RESET;
                default: val = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535)) :
                                                             16'($urandom_range(3, 24));
            endcase
            set_max_bytes(val);
            stop_at = bytes_sent + 32;
            while (bytes_sent < stop_at)
            begin
                build_string(s);
                send_string(s, pick_length(s.size()));
            end
        end

        settle();
        repeat (20) @(posedge clk);
        $display("Checked %0d output words from %0d bytes in %0d strings.",
                 words_taken, bytes_sent, strings_sent);
        $display("max_bytes was set %0d times, including 0, 1, 2, 3 and 65535.", settings_used);
        if (mismatches == 0 && due_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
